// ----- rtl/awsynth_pkg.sv -----
// ============================================================================
// awsynth_pkg: shared types and constants of the additive waveform synth
// Sequencer states, waveform modes, register indexes and fixed-point widths.
// ============================================================================
package awsynth_pkg;

    // waveform selection held in the mode register
    typedef enum logic [1:0] {
        MODE_SINE     = 2'd0,
        MODE_SAW      = 2'd1,
        MODE_SQUARE   = 2'd2,
        MODE_TRIANGLE = 2'd3
    } mode_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BASE,
        ST_PHASE,
        ST_INDEX,
        ST_ADDR,
        ST_SINE,
        ST_DIV,
        ST_QUOT,
        ST_DONE
    } state_t;

    // operand pair for the shared multiplier
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
    } mul_req_t;

    // configuration register indexes
    localparam logic [1:0] CFG_MODE = 2'd0;
    localparam logic [1:0] CFG_STEP = 2'd1;
    localparam logic [1:0] CFG_GAIN = 2'd2;

    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int PHASE_W     = 32;
    localparam int GAIN_W      = 15;
    localparam int GAIN_FRAC_W = 14;
    localparam int INDEX_W     = 16;
    localparam int QUAD_FRAC_W = 30;
    localparam int MUL_W       = 64;

    // sine magnitude is Q1.19, up to 2^19 inclusive
    localparam int SINE_MAG_W = 20;
    // gain * sine >> 14 stays below 2^20, as do all quotients
    localparam int QUOT_W     = 20;
    // harmonic sum magnitude stays below 2^25 for up to 1023 harmonics
    localparam int ACC_MIN_W  = 26;

    localparam int SQUARE_TOP   = 79;
    localparam int TRIANGLE_TOP = 127;

    // reset values of the registers
    localparam logic [PHASE_W-1:0] STEP_RESET = 32'd42949673;
    localparam logic [GAIN_W-1:0]  GAIN_RESET = 15'd16384;

    // sine table build: pi/2 in Q30 and the Taylor term divisors (2n)(2n+1)
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam int TAYLOR_TERMS = 6;
    localparam int unsigned TAYLOR_DIV [TAYLOR_TERMS] = '{6, 20, 42, 72, 110, 156};

endpackage

// ----- rtl/additive_waveform_synth.sv -----
// ============================================================================
// additive_waveform_synth: additive-synthesis oscillator
// Sums a fundamental sine and weighted sine harmonics for one sample index.
// ============================================================================
// Usage:
//   s_axis: one word per sample index; m_axis: one word per output sample.
//   cfg_we/cfg_addr/cfg_wdata write mode (0), phase step (1) and harmonic
//   gain (2); write only while no sample is in flight.
//   Every step runs through one shared 32x32 multiplier under a sequencer,
//   so one sample is taken at a time and s_axis_tready is low while it runs.
//   Each harmonic costs index multiply, table read, gain multiply and one
//   reciprocal multiply on the shared unit (two in triangle mode, which
//   divides twice).
//   The result sits in an output register; a new index is accepted while it
//   waits. If the next result is ready while m_axis is still stalled, the
//   sequencer holds it until the output register frees up.
//   Reset (aresetn low, synchronous) restores mode 3, step 42949673 and gain
//   16384 and empties the pipeline; the tables are constant, no clearing pass.
// ============================================================================
module additive_waveform_synth #(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int MAX_HARMONIC     = 250,
    parameter int SAMPLE_WIDTH     = 24
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // input words
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [15:0]                           s_axis_tdata,  // [15:0] sample_index
    // output words
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     m_axis_tdata,  // sample_value, zero fill
    // configuration writes
    input  logic                                  cfg_we,
    input  logic [awsynth_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [awsynth_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int OUT_W       = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int SIDX_W      = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int RECIP_DEPTH = ((MAX_HARMONIC > awsynth_pkg::TRIANGLE_TOP) ?
                                  MAX_HARMONIC : awsynth_pkg::TRIANGLE_TOP) + 1;
    localparam int HARM_W      = $clog2(RECIP_DEPTH);
    localparam int RECIP_W     = awsynth_pkg::QUOT_W + HARM_W;
    localparam int ACC_W       = (SAMPLE_WIDTH > awsynth_pkg::ACC_MIN_W) ?
                                 SAMPLE_WIDTH : awsynth_pkg::ACC_MIN_W;
    localparam logic signed [ACC_W-1:0] SAT_HI =
        ACC_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);
    localparam logic [HARM_W-1:0] HARM_SAW_TOP = HARM_W'(MAX_HARMONIC);
    localparam logic [HARM_W-1:0] HARM_SQR_TOP = HARM_W'(awsynth_pkg::SQUARE_TOP);
    localparam logic [HARM_W-1:0] HARM_TRI_TOP = HARM_W'(awsynth_pkg::TRIANGLE_TOP);

    // configuration registers
    awsynth_pkg::mode_t                  mode_reg, mode_next;
    logic [awsynth_pkg::PHASE_W-1:0]     step_reg, step_next;
    logic [awsynth_pkg::GAIN_W-1:0]      gain_reg, gain_next;

    // sequencer and datapath registers
    awsynth_pkg::state_t                 state_reg, state_next;
    logic [awsynth_pkg::INDEX_W-1:0]     sidx_reg, sidx_next;
    logic [awsynth_pkg::PHASE_W-1:0]     base_reg, base_next;
    logic [awsynth_pkg::PHASE_W-1:0]     phase_reg, phase_next;
    logic [HARM_W-1:0]                   harm_reg, harm_next;
    logic                                pass_reg, pass_next;
    logic signed [ACC_W-1:0]             acc_reg, acc_next;
    logic                                out_valid_reg, out_valid_next;
    logic [SAMPLE_WIDTH-1:0]             out_data_reg, out_data_next;

    // shared unit and table signals
    awsynth_pkg::mul_req_t               mul_req;
    logic [awsynth_pkg::MUL_W-1:0]       mul_prod;
    logic [SIDX_W-1:0]                   sine_raw;
    logic [SIDX_W-1:0]                   sine_addr;
    logic [awsynth_pkg::SINE_MAG_W-1:0]  sine_mag;
    logic [RECIP_W-1:0]                  recip;
    logic [awsynth_pkg::QUOT_W-1:0]      div_num;
    logic [awsynth_pkg::QUOT_W-1:0]      quot;
    logic signed [ACC_W-1:0]             mag_ext;
    logic signed [ACC_W-1:0]             quot_ext;
    logic signed [ACC_W-1:0]             acc_sat;
    logic                                last_harm;
    logic [1:0]                          harm_inc;
    logic [awsynth_pkg::PHASE_W-1:0]     phase_inc;
    logic                                out_free;

    awsynth_mul u_mul (
        .aclk (aclk),
        .req  (mul_req),
        .prod (mul_prod)
    );

    awsynth_sine_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .ADDR_W           (SIDX_W)
    ) u_sine_rom (
        .aclk    (aclk),
        .rd_addr (sine_addr),
        .rd_data (sine_mag)
    );

    awsynth_recip_rom #(
        .DEPTH  (RECIP_DEPTH),
        .ADDR_W (HARM_W),
        .DATA_W (RECIP_W)
    ) u_recip_rom (
        .aclk    (aclk),
        .rd_addr (harm_reg),
        .rd_data (recip)
    );

    // table index from phase fraction, mirrored in odd quadrants
    assign sine_raw  = mul_prod[awsynth_pkg::QUAD_FRAC_W +: SIDX_W];
    assign sine_addr = phase_reg[30] ? (SIDX_W'(SINE_TABLE_DEPTH) - sine_raw) : sine_raw;

    // quotient pieces
    assign div_num  = mul_prod[awsynth_pkg::GAIN_FRAC_W +: awsynth_pkg::QUOT_W];
    assign quot     = mul_prod[RECIP_W +: awsynth_pkg::QUOT_W];
    assign mag_ext  = $signed({{(ACC_W - awsynth_pkg::SINE_MAG_W){1'b0}}, sine_mag});
    assign quot_ext = $signed({{(ACC_W - awsynth_pkg::QUOT_W){1'b0}}, quot});

    // harmonic walk: sawtooth steps by one, the odd series by two
    assign harm_inc  = (mode_reg == awsynth_pkg::MODE_SAW) ? 2'd1 : 2'd2;
    assign phase_inc = (mode_reg == awsynth_pkg::MODE_SAW) ? base_reg : {base_reg[30:0], 1'b0};
    assign last_harm = (mode_reg == awsynth_pkg::MODE_SINE) ||
                       (mode_reg == awsynth_pkg::MODE_SAW && harm_reg == HARM_SAW_TOP) ||
                       (mode_reg == awsynth_pkg::MODE_SQUARE && harm_reg == HARM_SQR_TOP) ||
                       (mode_reg == awsynth_pkg::MODE_TRIANGLE && harm_reg == HARM_TRI_TOP);

    // output clamp
    always_comb begin
        priority if (acc_reg > SAT_HI) begin
            acc_sat = SAT_HI;
        end else if (acc_reg < SAT_LO) begin
            acc_sat = SAT_LO;
        end else begin
            acc_sat = acc_reg;
        end
    end

    assign out_free = !out_valid_reg || m_axis_tready;

    // configuration register writes
    always_comb begin
        mode_next = mode_reg;
        step_next = step_reg;
        gain_next = gain_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                awsynth_pkg::CFG_MODE: mode_next = awsynth_pkg::mode_t'(cfg_wdata[1:0]);
                awsynth_pkg::CFG_STEP: step_next = cfg_wdata;
                awsynth_pkg::CFG_GAIN: gain_next = cfg_wdata[awsynth_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer: next state, multiplier operands, accumulation
    always_comb begin
        state_next     = state_reg;
        sidx_next      = sidx_reg;
        base_next      = base_reg;
        phase_next     = phase_reg;
        harm_next      = harm_reg;
        pass_next      = pass_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        mul_req        = '0;
        s_axis_tready  = 1'b0;

        unique case (state_reg)
            awsynth_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    sidx_next  = s_axis_tdata;
                    state_next = awsynth_pkg::ST_BASE;
                end
            end
            // fundamental phase = index * step mod 2^32 (one full turn)
            awsynth_pkg::ST_BASE: begin
                mul_req.a  = 32'(sidx_reg);
                mul_req.b  = step_reg;
                state_next = awsynth_pkg::ST_PHASE;
            end
            awsynth_pkg::ST_PHASE: begin
                base_next  = mul_prod[awsynth_pkg::PHASE_W-1:0];
                phase_next = mul_prod[awsynth_pkg::PHASE_W-1:0];
                harm_next  = HARM_W'(1);
                acc_next   = '0;
                state_next = awsynth_pkg::ST_INDEX;
            end
            // table index = fraction * depth >> 30
            awsynth_pkg::ST_INDEX: begin
                mul_req.a  = {2'b00, phase_reg[awsynth_pkg::QUAD_FRAC_W-1:0]};
                mul_req.b  = 32'(SINE_TABLE_DEPTH);
                state_next = awsynth_pkg::ST_ADDR;
            end
            awsynth_pkg::ST_ADDR: begin
                state_next = awsynth_pkg::ST_SINE;
            end
            awsynth_pkg::ST_SINE: begin
                if (harm_reg == HARM_W'(1)) begin
                    // fundamental goes in unscaled
                    acc_next = phase_reg[31] ? -mag_ext : mag_ext;
                    if (last_harm) begin
                        state_next = awsynth_pkg::ST_DONE;
                    end else begin
                        harm_next  = harm_reg + HARM_W'(harm_inc);
                        phase_next = phase_reg + phase_inc;
                        state_next = awsynth_pkg::ST_INDEX;
                    end
                end else begin
                    mul_req.a  = 32'(gain_reg);
                    mul_req.b  = 32'(sine_mag);
                    state_next = awsynth_pkg::ST_DIV;
                end
            end
            // divide by the harmonic number through its reciprocal
            awsynth_pkg::ST_DIV: begin
                mul_req.a  = 32'(div_num);
                mul_req.b  = 32'(recip);
                pass_next  = 1'b0;
                state_next = awsynth_pkg::ST_QUOT;
            end
            awsynth_pkg::ST_QUOT: begin
                if (mode_reg == awsynth_pkg::MODE_TRIANGLE && !pass_reg) begin
                    // triangle divides by i twice
                    mul_req.a = 32'(quot);
                    mul_req.b = 32'(recip);
                    pass_next = 1'b1;
                end else begin
                    pass_next = 1'b0;
                    if (phase_reg[31] ^ (mode_reg == awsynth_pkg::MODE_TRIANGLE)) begin
                        acc_next = acc_reg - quot_ext;
                    end else begin
                        acc_next = acc_reg + quot_ext;
                    end
                    if (last_harm) begin
                        state_next = awsynth_pkg::ST_DONE;
                    end else begin
                        harm_next  = harm_reg + HARM_W'(harm_inc);
                        phase_next = phase_reg + phase_inc;
                        state_next = awsynth_pkg::ST_INDEX;
                    end
                end
            end
            // hand the sample to the output register once it is free
            awsynth_pkg::ST_DONE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = acc_sat[SAMPLE_WIDTH-1:0];
                    state_next     = awsynth_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = awsynth_pkg::ST_IDLE;
            end
        endcase
    end

    // control state with reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= awsynth_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            pass_reg      <= 1'b0;
            mode_reg      <= awsynth_pkg::MODE_TRIANGLE;
            step_reg      <= awsynth_pkg::STEP_RESET;
            gain_reg      <= awsynth_pkg::GAIN_RESET;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pass_reg      <= pass_next;
            mode_reg      <= mode_next;
            step_reg      <= step_next;
            gain_reg      <= gain_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        sidx_reg     <= sidx_next;
        base_reg     <= base_next;
        phase_reg    <= phase_next;
        harm_reg     <= harm_next;
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'(out_data_reg);

`ifndef SYNTH
    // an accepted word always starts the phase multiply
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg == awsynth_pkg::ST_BASE))
        else $error("accepted word did not start a sample");

    // a new result only comes out of the done state
    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> $past(state_reg == awsynth_pkg::ST_DONE))
        else $error("result appeared outside the done state");

    // a finished sample waits while the output word is stalled
    a_done_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == awsynth_pkg::ST_DONE && m_axis_tvalid && !m_axis_tready)
        |=> (state_reg == awsynth_pkg::ST_DONE))
        else $error("finished sample overwrote a stalled word");

    // the second division pass belongs to triangle mode only
    a_pass_triangle: assert property (@(posedge aclk) disable iff (!aresetn)
        pass_reg |-> (mode_reg == awsynth_pkg::MODE_TRIANGLE))
        else $error("second division pass outside triangle mode");
`endif

endmodule

// ----- rtl/awsynth_mul.sv -----
// ============================================================================
// awsynth_mul: shared unsigned multiplier
// One 32x32 multiply with a registered 64-bit product, reused for every step.
// ============================================================================
module awsynth_mul (
    input  logic                           aclk,
    input  awsynth_pkg::mul_req_t          req,
    output logic [awsynth_pkg::MUL_W-1:0]  prod
);

    logic [awsynth_pkg::MUL_W-1:0] prod_reg;

    // registered product
    always_ff @(posedge aclk) begin
        prod_reg <= awsynth_pkg::MUL_W'(req.a) * awsynth_pkg::MUL_W'(req.b);
    end

    assign prod = prod_reg;

endmodule

// ----- rtl/awsynth_sine_rom.sv -----
// ============================================================================
// awsynth_sine_rom: quarter-wave sine table
// Q1.19 magnitudes of sin over [0, pi/2], built at elaboration, registered read.
// ============================================================================
module awsynth_sine_rom #(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int ADDR_W           = 11
) (
    input  logic                                aclk,
    input  logic [ADDR_W-1:0]                   rd_addr,
    output logic [awsynth_pkg::SINE_MAG_W-1:0]  rd_data
);

    typedef logic [SINE_TABLE_DEPTH:0][awsynth_pkg::SINE_MAG_W-1:0] sine_rom_t;

    // Taylor series to the x^13 term in Q30, rounded to Q19
    function automatic sine_rom_t build_sine();
        sine_rom_t   rom;
        logic [63:0] ang;
        logic [63:0] x2;
        logic [63:0] term;
        logic signed [63:0] sum;
        logic [63:0] rnd;
        rom = '0;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
            ang  = (awsynth_pkg::HALF_PI_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
            x2   = (ang * ang) >> 30;
            term = ang;
            sum  = $signed(ang);
            for (int n = 0; n < awsynth_pkg::TAYLOR_TERMS; n++) begin
                term = ((term * x2) >> 30) / awsynth_pkg::TAYLOR_DIV[n];
                if (n % 2 == 0) begin
                    sum = sum - $signed(term);
                end else begin
                    sum = sum + $signed(term);
                end
            end
            if (sum < 0) begin
                sum = '0;
            end
            rnd = ($unsigned(sum) + 64'd1024) >> 11;
            rom[k] = rnd[awsynth_pkg::SINE_MAG_W-1:0];
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine();

    logic [awsynth_pkg::SINE_MAG_W-1:0] rd_data_reg;

    // registered table read
    always_ff @(posedge aclk) begin
        rd_data_reg <= SINE_ROM[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/awsynth_recip_rom.sv -----
// ============================================================================
// awsynth_recip_rom: reciprocal table for exact division by a harmonic number
// Entry d holds ceil(2^DATA_W / d); (n * entry) >> DATA_W equals floor(n / d)
// for every n below 2^QUOT_W. Registered read.
// ============================================================================
module awsynth_recip_rom #(
    parameter int DEPTH  = 251,
    parameter int ADDR_W = 8,
    parameter int DATA_W = 28
) (
    input  logic              aclk,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    typedef logic [DEPTH-1:0][DATA_W-1:0] recip_rom_t;

    // long division of (2^DATA_W + d - 1) by d, one bit per step
    function automatic recip_rom_t build_recip();
        recip_rom_t      rom;
        logic [63:0]     num;
        logic [63:0]     rem;
        logic [DATA_W:0] quo;
        rom = '0;
        for (int d = 2; d < DEPTH; d++) begin
            num = (64'd1 << DATA_W) + 64'(d) - 64'd1;
            rem = '0;
            quo = '0;
            for (int b = DATA_W; b >= 0; b--) begin
                rem = {rem[62:0], num[b]};
                if (rem >= 64'(d)) begin
                    rem    = rem - 64'(d);
                    quo[b] = 1'b1;
                end
            end
            rom[d] = quo[DATA_W-1:0];
        end
        return rom;
    endfunction

    localparam recip_rom_t RECIP_ROM = build_recip();

    logic [DATA_W-1:0] rd_data_reg;

    // registered table read
    always_ff @(posedge aclk) begin
        rd_data_reg <= RECIP_ROM[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
